// ----- design/fpfa_pkg.sv -----
// Shared types and constants for the fixed-partition fit allocator.
package fpfa_pkg;

	localparam int SLOTS       = 16;
	localparam int SLOT_BITS   = 4;
	localparam int SIZE_BITS   = 16;
	localparam int COUNT_BITS  = 5;
	localparam int POLICY_BITS = 2;
	localparam int CFG_BITS    = 5;
	localparam int ADDR_BITS   = 1;

	typedef enum logic [POLICY_BITS-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_policy_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic [ADDR_BITS-1:0] {
		REG_FIT_POLICY      = 1'b0,
		REG_PARTITION_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic                 operation;
		logic [SLOT_BITS-1:0] slot_index;
		logic [SIZE_BITS-1:0] size_value;
	} req_t;

	typedef struct packed {
		logic                 granted;
		logic [SLOT_BITS-1:0] chosen_slot;
		logic [SIZE_BITS-1:0] space_left;
	} rsp_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [SLOT_BITS-1:0] idx;
		logic [SIZE_BITS-1:0] rem;
	} tok_t;

	// Write command broadcast to every cell.
	typedef struct packed {
		logic                 ld;
		logic                 al;
		logic [SLOT_BITS-1:0] slot;
		logic [SIZE_BITS-1:0] value;
	} wr_t;

endpackage

// ----- design/fixed_partition_fit_allocator.sv -----
// Top level of the fixed-partition fit allocator: command port, config and cell chain.
//
// Channel   Direction  Handshake              Payload
// request   in         start & !busy          fpfa_pkg::req_t
// result    out        done, one cycle         fpfa_pkg::rsp_t
// config    in         cfg_we                 cfg_addr, cfg_wdata
//
// A load is answered directly: the result strobes in the cycle after the request.
// An allocate sends a search token down the chain of 16 cells, one cell per
// cycle; the chosen cell is updated and the result is registered as the
// token leaves the last cell. busy stays high over the scan.
// Reset clears all partitions and both registers. The receiver cannot stall.
module fixed_partition_fit_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  fpfa_pkg::req_t                 request,
	output logic                           done,
	output fpfa_pkg::rsp_t                 result,
	input  logic                           cfg_we,
	input  logic [fpfa_pkg::ADDR_BITS-1:0] cfg_addr,
	input  logic [fpfa_pkg::CFG_BITS-1:0]  cfg_wdata
);

	logic [fpfa_pkg::POLICY_BITS-1:0] policy_q;
	logic [fpfa_pkg::COUNT_BITS-1:0]  count_q;
	logic                             busy_q;
	logic                             launch_q;
	logic [fpfa_pkg::SIZE_BITS-1:0]   req_q;
	logic                             done_q;
	fpfa_pkg::rsp_t                   result_q;

	fpfa_pkg::tok_t                   tok [fpfa_pkg::SLOTS+1];
	fpfa_pkg::tok_t                   tok_end;
	fpfa_pkg::wr_t                    wr;
	logic [fpfa_pkg::SLOTS-1:0]       active;
	logic [fpfa_pkg::SLOTS:0]         tok_valid;
	logic                             accept;

	assign accept  = start && !busy_q;
	assign tok_end = tok[fpfa_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				fpfa_pkg::REG_FIT_POLICY:      policy_q <= cfg_wdata[fpfa_pkg::POLICY_BITS-1:0];
				fpfa_pkg::REG_PARTITION_COUNT: count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Load and finished allocate share the broadcast write bus.
	always_comb begin
		wr = '0;
		if (accept && (request.operation == fpfa_pkg::OP_LOAD)) begin
			wr.ld    = 1'b1;
			wr.slot  = request.slot_index;
			wr.value = request.size_value;
		end else if (tok_end.valid && tok_end.found) begin
			wr.al    = 1'b1;
			wr.slot  = tok_end.idx;
			wr.value = req_q;
		end
	end

	assign tok[0] = '{valid: launch_q, found: 1'b0, idx: '0, rem: '0};

	for (genvar j = 0; j < fpfa_pkg::SLOTS; j++) begin : g_cell
		// Counts above the slot total saturate, so a plain compare suffices.
		assign active[j] = count_q > fpfa_pkg::COUNT_BITS'(j);

		fpfa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (fpfa_pkg::SLOT_BITS'(j)),
			.active  (active[j]),
			.policy  (policy_q),
			.req_size(req_q),
			.wr      (wr),
			.tok_in  (tok[j]),
			.tok_out (tok[j+1])
		);
	end

	for (genvar k = 0; k <= fpfa_pkg::SLOTS; k++) begin : g_valid
		assign tok_valid[k] = tok[k].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= accept && (request.operation == fpfa_pkg::OP_ALLOC);
			done_q   <= (accept && (request.operation == fpfa_pkg::OP_LOAD)) || tok_end.valid;
			if (accept && (request.operation == fpfa_pkg::OP_ALLOC)) begin
				busy_q <= 1'b1;
			end else if (tok_end.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request.size_value;
		end
		if (accept && (request.operation == fpfa_pkg::OP_LOAD)) begin
			result_q.granted     <= 1'b1;
			result_q.chosen_slot <= request.slot_index;
			result_q.space_left  <= request.size_value;
		end else if (tok_end.valid) begin
			if (tok_end.found) begin
				result_q.granted     <= 1'b1;
				result_q.chosen_slot <= tok_end.idx;
				result_q.space_left  <= tok_end.rem - req_q;
			end else begin
				result_q <= '0;
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while scan still running");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one search token in the chain");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.granted) |-> (result.chosen_slot == '0 && result.space_left == '0))
		else $error("failure result carries nonzero fields");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.operation == fpfa_pkg::OP_ALLOC) |=> (busy && tok[0].valid))
		else $error("allocate request did not launch a scan");

endmodule

// ----- design/fpfa_cell.sv -----
// One partition cell: holds size and remaining space, updates the passing search token.
module fpfa_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [fpfa_pkg::SLOT_BITS-1:0] cell_id,
	input  logic                           active,
	input  logic [fpfa_pkg::POLICY_BITS-1:0] policy,
	input  logic [fpfa_pkg::SIZE_BITS-1:0] req_size,
	input  fpfa_pkg::wr_t                  wr,
	input  fpfa_pkg::tok_t                 tok_in,
	output fpfa_pkg::tok_t                 tok_out
);

	logic [fpfa_pkg::SIZE_BITS-1:0] size_q;
	logic [fpfa_pkg::SIZE_BITS-1:0] rem_q;
	fpfa_pkg::tok_t                 tok_q;
	logic                           eligible;
	logic                           better;
	logic                           take;

	assign eligible = active && (rem_q == size_q) && (req_size <= rem_q);

	always_comb begin
		case (policy)
			fpfa_pkg::FIT_BEST:  better = rem_q < tok_in.rem;
			fpfa_pkg::FIT_WORST: better = rem_q > tok_in.rem;
			default:             better = 1'b0;
		endcase
	end

	assign take = eligible && (!tok_in.found || better);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			rem_q  <= '0;
		end else if (wr.ld && (wr.slot == cell_id)) begin
			size_q <= wr.value;
			rem_q  <= wr.value;
		end else if (wr.al && (wr.slot == cell_id)) begin
			rem_q <= rem_q - wr.value;
		end
	end

	// Advance the token one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			if (tok_in.valid) begin
				tok_q.found <= tok_in.found | eligible;
				tok_q.idx   <= take ? cell_id : tok_in.idx;
				tok_q.rem   <= take ? rem_q : tok_in.rem;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- dv/alloc_scoreboard_pkg.sv -----
// Scoreboard for the fixed-partition fit allocator: partition predictor and result checks.
`timescale 1ns / 1ps

package alloc_scoreboard_pkg;

	import fpfa_pkg::*;

	class alloc_scoreboard;

		logic [SIZE_BITS-1:0]   part_size [SLOTS];
		logic [SIZE_BITS-1:0]   part_left [SLOTS];
		logic [POLICY_BITS-1:0] policy;
		logic [COUNT_BITS-1:0]  count;
		rsp_t                   grant_queue [$];
		int                     errors;

		function new();
			foreach (part_size[j]) begin
				part_size[j] = '0;
				part_left[j] = '0;
			end
			policy = '0;
			count  = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [ADDR_BITS-1:0] addr, logic [CFG_BITS-1:0] data);
			if (addr == REG_FIT_POLICY) begin
				policy = data[POLICY_BITS-1:0];
			end else begin
				count = data[COUNT_BITS-1:0];
			end
		endfunction

		// Apply one request to the partition table and return the grant it yields.
		function rsp_t predict_fit(req_t r);
			rsp_t rsp;
			int   limit;
			int   pick;
			bit   found;
			rsp   = '0;
			pick  = 0;
			found = 1'b0;
			if (r.operation == OP_LOAD) begin
				part_size[r.slot_index] = r.size_value;
				part_left[r.slot_index] = r.size_value;
				rsp.granted     = 1'b1;
				rsp.chosen_slot = r.slot_index;
				rsp.space_left  = r.size_value;
				return rsp;
			end
			limit = (count > SLOTS) ? SLOTS : int'(count);
			for (int j = 0; j < limit; j++) begin
				// only untouched partitions big enough take part
				if (part_left[j] == part_size[j] && r.size_value <= part_left[j]) begin
					if (!found) begin
						found = 1'b1;
						pick  = j;
						if (policy != FIT_BEST && policy != FIT_WORST)
							break;
					end else if (policy == FIT_BEST && part_left[j] < part_left[pick]) begin
						pick = j;
					end else if (policy == FIT_WORST && part_left[j] > part_left[pick]) begin
						pick = j;
					end
				end
			end
			if (found) begin
				part_left[pick] = part_left[pick] - r.size_value;
				rsp.granted     = 1'b1;
				rsp.chosen_slot = SLOT_BITS'(pick);
				rsp.space_left  = part_left[pick];
			end
			return rsp;
		endfunction

		function void note_request(req_t r);
			grant_queue.push_back(predict_fit(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (grant_queue.size() == 0) begin
				$error("result with no request pending: granted %0d slot %0d left %0d",
					got.granted, got.chosen_slot, got.space_left);
				errors++;
				return;
			end
			want = grant_queue.pop_front();
			if (got.granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, got.granted);
				errors++;
			end
			if (got.chosen_slot !== want.chosen_slot) begin
				$error("chosen_slot: expected %0d, got %0d", want.chosen_slot, got.chosen_slot);
				errors++;
			end
			if (got.space_left !== want.space_left) begin
				$error("space_left: expected %0d, got %0d", want.space_left, got.space_left);
				errors++;
			end
		endfunction

		function int outstanding();
			return grant_queue.size();
		endfunction

	endclass

endpackage

// ----- dv/tb.sv -----
// Testbench top for the fixed-partition fit allocator: clock, reset, drivers and monitor.
`timescale 1ns / 1ps

module tb;

	import fpfa_pkg::*;
	import alloc_scoreboard_pkg::*;

	// policy code three falls back to first fit
	localparam logic [POLICY_BITS-1:0] FIT_SPARE = 2'd3;
	localparam int PHASES    = 10;
	localparam int PHASE_LEN = 153;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	req_t                 request   = '0;
	logic                 done;
	rsp_t                 result;
	logic                 cfg_we    = 1'b0;
	logic [ADDR_BITS-1:0] cfg_addr  = '0;
	logic [CFG_BITS-1:0]  cfg_wdata = '0;
	logic                 req_taken = 1'b0;

	alloc_scoreboard sb = new();

	fixed_partition_fit_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Sample everything at the rising edge; results are checked before the
	// request accepted at the same edge is noted.
	always @(posedge clk) begin
		req_taken = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_addr, cfg_wdata);
			if (done)
				sb.check_result(result);
			if (start && !busy) begin
				sb.note_request(request);
				req_taken = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with start still high.
	task automatic send_request(input req_t r);
		start   = 1'b1;
		request = r;
		do @(negedge clk); while (!req_taken);
	endtask

	task automatic send_load(input int slot, input int size);
		req_t r;
		r.operation  = OP_LOAD;
		r.slot_index = SLOT_BITS'(slot);
		r.size_value = SIZE_BITS'(size);
		send_request(r);
	endtask

	task automatic send_alloc(input int size);
		req_t r;
		r.operation  = OP_ALLOC;
		r.slot_index = SLOT_BITS'($urandom_range(0, SLOTS-1));
		r.size_value = SIZE_BITS'(size);
		send_request(r);
	endtask

	// Hold off until every request has answered and the block is idle.
	task automatic drain_requests();
		start = 1'b0;
		while (sb.outstanding() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t addr, input int data);
		cfg_we    = 1'b1;
		cfg_addr  = addr;
		cfg_wdata = CFG_BITS'(data);
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	function automatic req_t make_request(input int cnt);
		req_t r;
		int   live;
		int   sel;
		live = (cnt > SLOTS) ? SLOTS : cnt;
		sel  = $urandom_range(0, 99);
		r.operation = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_ALLOC;
		if (r.operation == OP_LOAD && live > 0 && $urandom_range(0, 9) < 7)
			r.slot_index = SLOT_BITS'($urandom_range(0, live-1));
		else
			r.slot_index = SLOT_BITS'($urandom_range(0, SLOTS-1));
		if (r.operation == OP_LOAD) begin
			// coarse sizes make ties between partitions common
			if (sel < 10)
				r.size_value = '0;
			else if (sel < 15)
				r.size_value = '1;
			else if (sel < 60)
				r.size_value = SIZE_BITS'(8 * $urandom_range(1, 8));
			else
				r.size_value = SIZE_BITS'($urandom_range(0, 65535));
		end else begin
			if (sel < 8)
				r.size_value = '0;
			else if (sel < 12)
				r.size_value = '1;
			else if (sel < 65)
				r.size_value = SIZE_BITS'($urandom_range(1, 64));
			else
				r.size_value = SIZE_BITS'($urandom_range(0, 65535));
		end
		return r;
	endfunction

	initial begin
		#5_000_000;
		$display("FAIL fixed_partition_fit_allocator");
		$finish;
	end

	initial begin
		int policies [PHASES] = '{0, 1, 2, 3, 1, 2, 0, 1, 2, 3};
		int counts   [PHASES] = '{16, 16, 16, 16, 5, 31, 1, 9, 24, 16};
		bit calm;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no partitions in use after reset
		send_alloc(0);
		drain_requests();
		write_reg(REG_PARTITION_COUNT, 16);
		write_reg(REG_FIT_POLICY, FIT_BEST);
		send_load(0, 16'hFFFF);
		send_load(15, 16'hFFFF);
		send_load(1, 100);
		send_load(2, 50);
		send_load(3, 100);
		send_load(4, 50);
		// zero request lands on an empty partition and leaves it untouched
		send_alloc(0);
		send_alloc(50);
		send_alloc(50);
		send_alloc(16'hFFFF);
		send_alloc(16'hFFFF);
		send_alloc(16'hFFFF);
		drain_requests();
		write_reg(REG_FIT_POLICY, FIT_WORST);
		send_alloc(1);
		send_alloc(1);
		send_alloc(0);
		drain_requests();
		write_reg(REG_FIT_POLICY, FIT_SPARE);
		send_load(6, 7);
		send_alloc(7);
		drain_requests();
		// count above the slot total saturates
		write_reg(REG_PARTITION_COUNT, 31);
		write_reg(REG_FIT_POLICY, FIT_FIRST);
		send_load(15, 200);
		send_alloc(150);

		for (int p = 0; p < PHASES; p++) begin
			drain_requests();
			write_reg(REG_FIT_POLICY, policies[p]);
			write_reg(REG_PARTITION_COUNT, counts[p]);
			calm = (p == 3 || p == 4);
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (!calm && $urandom_range(0, 99) < 21) begin
					start = 1'b0;
					if ($urandom_range(0, 3) == 0)
						repeat ($urandom_range(5, 24)) @(negedge clk);
					else
						repeat ($urandom_range(1, 3)) @(negedge clk);
				end
				send_request(make_request(counts[p]));
			end
		end

		drain_requests();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("PASS fixed_partition_fit_allocator");
		else
			$display("FAIL fixed_partition_fit_allocator");
		$finish;
	end

endmodule
